// File: sv/nfo_pkg.sv
package nfo_pkg;

	localparam int VECTOR_SIZE_DEFAULT     = 64;
	localparam int SINE_TABLE_BITS_DEFAULT = 10;
	localparam int QUEUE_DEPTH_DEFAULT     = 4;

	localparam int SAMPLE_W = 16;
	localparam int PHASE_W  = 32;

	// item codes
	localparam logic MODE_SAMPLE = 1'b0;
	localparam logic MODE_UPDATE = 1'b1;

	// path_select codes
	localparam logic PATH_EST  = 1'b0;
	localparam logic PATH_BEAM = 1'b1;

	// q30 constants for the table build
	localparam logic [63:0] Q30_ONE     = 64'd1073741824;
	localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [PHASE_W-1:0]         phase_t;

	// one sample request as it travels from front to back
	typedef struct packed {
		logic    path;
		logic    last;
		phase_t  phase;
		sample_t re;
		sample_t im;
	} request_t;

	typedef struct packed {
		logic     valid;
		request_t req;
	} req_slot_t;

	// first-quadrant sine of p / 2^(bits-2) quarter turns, q1.15, clamped
	function automatic logic [SAMPLE_W-1:0] quarter_sin(input logic [63:0] p,
			input int unsigned bits);
		logic [63:0] th;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] r;
		th = (p * Q30_HALF_PI) >> (bits - 2);
		x2 = (th * th) >> 30;
		t  = Q30_ONE - x2 / 64'd110;
		t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
		t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
		t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
		t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
		s  = (th * t) >> 30;
		r  = (s + 64'd16384) >> 15;
		if (r > 64'd32767) begin
			r = 64'd32767;
		end
		return r[SAMPLE_W-1:0];
	endfunction

endpackage

// File: sv/nco_frequency_offset_mixer_unit.sv
// nco frequency-offset mixer for complex i/q samples
//
// input channel (in_valid / in_stall): one request per cycle while in_stall
//   is low. mode selects a sample request or a frequency offset update;
//   updates add freq_delta to the offset register and give no output.
// output channel (out_valid / out_stall): one output per sample request, in
//   order, with vector_last high on the last sample of every VECTOR_SIZE vector.
// config: cfg_we writes path_select (0 = rotate est sample, 1 = pass beam
//   sample through); write it only while the block is idle.
// throughput: one request per cycle while in_stall is low; the phase update is
//   a single 32-bit subtract in the front, the back is a three-stage pipe
//   (table lookup, multiply, round/saturate) that moves one sample per cycle
//   while not stalled; each accepted sample goes through the queue first.
// stall: a stalled output freezes the back pipe; the queue between front and
//   back holds up to QUEUE_DEPTH sample requests, then in_stall rises.
// reset: phase, frequency offset, vector position and path_select go to zero;
//   queue and pipe are emptied.
module nco_frequency_offset_mixer_unit #(
	parameter int VECTOR_SIZE     = nfo_pkg::VECTOR_SIZE_DEFAULT,
	parameter int SINE_TABLE_BITS = nfo_pkg::SINE_TABLE_BITS_DEFAULT,
	parameter int QUEUE_DEPTH     = nfo_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration write
	input  logic               cfg_we,
	input  logic [0:0]         cfg_wdata,
	// request channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               mode,
	input  nfo_pkg::sample_t   est_i,
	input  nfo_pkg::sample_t   est_q,
	input  nfo_pkg::sample_t   beam_i,
	input  nfo_pkg::sample_t   beam_q,
	input  logic signed [31:0] freq_delta,
	// result channel
	output logic               out_valid,
	input  logic               out_stall,
	output nfo_pkg::sample_t   out_i,
	output nfo_pkg::sample_t   out_q,
	output logic               vector_last
);
	import nfo_pkg::*;

	// front to queue: classified sample request with its phase and vector mark
	req_slot_t push;
	// queue to back: oldest waiting request
	req_slot_t head;
	logic      queue_full;
	logic      pop;

	// front: config register, offset updates, phase accumulator, vector count
	nfo_front #(
		.VECTOR_SIZE(VECTOR_SIZE)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.est_i      (est_i),
		.est_q      (est_q),
		.beam_i     (beam_i),
		.beam_q     (beam_q),
		.freq_delta (freq_delta),
		.queue_full (queue_full),
		.push       (push)
	);

	// short queue decoupling the two sides
	nfo_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (queue_full),
		.head   (head),
		.pop    (pop)
	);

	// back: sine/cosine lookup, complex multiply, round and saturate
	nfo_back #(
		.SINE_TABLE_BITS(SINE_TABLE_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_i       (out_i),
		.out_q       (out_q),
		.vector_last (vector_last)
	);

endmodule

// File: sv/nfo_front.sv
module nfo_front #(
	parameter int VECTOR_SIZE = nfo_pkg::VECTOR_SIZE_DEFAULT
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [0:0]               cfg_wdata,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     mode,
	input  nfo_pkg::sample_t         est_i,
	input  nfo_pkg::sample_t         est_q,
	input  nfo_pkg::sample_t         beam_i,
	input  nfo_pkg::sample_t         beam_q,
	input  logic signed [31:0]       freq_delta,
	input  logic                     queue_full,
	output nfo_pkg::req_slot_t       push
);
	import nfo_pkg::*;

	localparam int IDX_W = (VECTOR_SIZE > 1) ? $clog2(VECTOR_SIZE) : 1;

	logic             path_select_q;
	phase_t           phase_acc_q;
	phase_t           freq_offset_q;
	logic [IDX_W-1:0] sample_idx_q;

	logic   accept;
	logic   is_sample;
	logic   last;
	phase_t phase_next;

	assign in_stall   = queue_full;
	assign accept     = in_valid && !queue_full;
	assign is_sample  = (mode == MODE_SAMPLE);
	assign last       = (sample_idx_q == IDX_W'(VECTOR_SIZE - 1));
	assign phase_next = phase_acc_q - freq_offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			path_select_q <= PATH_EST;
			phase_acc_q   <= '0;
			freq_offset_q <= '0;
			sample_idx_q  <= '0;
		end else begin
			if (cfg_we) begin
				path_select_q <= cfg_wdata[0];
			end
			if (accept && !is_sample) begin
				freq_offset_q <= freq_offset_q + phase_t'(freq_delta);
			end
			if (accept && is_sample) begin
				if (path_select_q == PATH_EST) begin
					phase_acc_q <= phase_next;
				end
				sample_idx_q <= last ? '0 : sample_idx_q + IDX_W'(1);
			end
		end
	end

	always_comb begin
		push.valid     = accept && is_sample;
		push.req.path  = path_select_q;
		push.req.last  = last;
		push.req.phase = phase_next;
		push.req.re    = (path_select_q == PATH_BEAM) ? beam_i : est_i;
		push.req.im    = (path_select_q == PATH_BEAM) ? beam_q : est_q;
	end

endmodule

// File: sv/nfo_queue.sv
module nfo_queue #(
	parameter int QUEUE_DEPTH = nfo_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  nfo_pkg::req_slot_t push,
	output logic               full,
	output nfo_pkg::req_slot_t head,
	input  logic               pop
);
	import nfo_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	request_t         slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(QUEUE_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.req   = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.valid) begin
			slots_q[wr_ptr_q] <= push.req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push.valid && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push.valid) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> !full)
		else $error("push into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid)
		else $error("pop from empty queue");

endmodule

// File: sv/nfo_back.sv
module nfo_back #(
	parameter int SINE_TABLE_BITS = nfo_pkg::SINE_TABLE_BITS_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  nfo_pkg::req_slot_t head,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output nfo_pkg::sample_t   out_i,
	output nfo_pkg::sample_t   out_q,
	output logic               vector_last
);
	import nfo_pkg::*;

	localparam int QTR    = 1 << (SINE_TABLE_BITS - 2);
	localparam int ADDR_W = SINE_TABLE_BITS - 1;
	localparam int PROD_W = 2 * SAMPLE_W;
	localparam int SUM_W  = PROD_W + 1;

	// quarter-wave sine table, built at elaboration
	sample_t qtab [QTR+1];
	for (genvar k = 0; k <= QTR; k++) begin : g_qtab
		assign qtab[k] = sample_t'(quarter_sin(64'(k), SINE_TABLE_BITS));
	end

	function automatic sample_t round_sat(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] shifted;
		shifted = (v + SUM_W'(16384)) >>> 15;
		if (shifted > SUM_W'(32767)) begin
			return sample_t'(16'sd32767);
		end else if (shifted < -SUM_W'(32768)) begin
			return sample_t'(-17'sd32768);
		end
		return shifted[SAMPLE_W-1:0];
	endfunction

	logic adv;

	logic [1:0]        quad_sin;
	logic [1:0]        quad_cos;
	logic [ADDR_W-1:0] addr_fwd;
	logic [ADDR_W-1:0] addr_rev;
	sample_t           mag_sin;
	sample_t           mag_cos;
	sample_t           sin_val;
	sample_t           cos_val;

	logic    valid_s1;
	logic    path_s1;
	logic    last_s1;
	sample_t re_s1;
	sample_t im_s1;
	sample_t sin_s1;
	sample_t cos_s1;

	logic                     valid_s2;
	logic                     path_s2;
	logic                     last_s2;
	sample_t                  re_s2;
	sample_t                  im_s2;
	logic signed [PROD_W-1:0] prod_rc_s2;
	logic signed [PROD_W-1:0] prod_is_s2;
	logic signed [PROD_W-1:0] prod_rs_s2;
	logic signed [PROD_W-1:0] prod_ic_s2;

	logic signed [SUM_W-1:0] sum_re;
	logic signed [SUM_W-1:0] sum_im;

	logic    out_valid_q;
	sample_t out_i_q;
	sample_t out_q_q;
	logic    vector_last_q;

	// whole pipe moves when the output register is free or being taken
	assign adv = !out_valid_q || !out_stall;
	assign pop = head.valid && adv;

	// table lookup, mirrored and negated by quadrant
	always_comb begin
		quad_sin = head.req.phase[PHASE_W-1 -: 2];
		quad_cos = quad_sin + 2'd1;
		addr_fwd = {1'b0, head.req.phase[PHASE_W-3 -: SINE_TABLE_BITS-2]};
		addr_rev = ADDR_W'(QTR) - addr_fwd;
		mag_sin  = quad_sin[0] ? qtab[addr_rev] : qtab[addr_fwd];
		mag_cos  = quad_cos[0] ? qtab[addr_rev] : qtab[addr_fwd];
		sin_val  = quad_sin[1] ? -mag_sin : mag_sin;
		cos_val  = quad_cos[1] ? -mag_cos : mag_cos;
	end

	always_comb begin
		sum_re = SUM_W'(prod_rc_s2) - SUM_W'(prod_is_s2);
		sum_im = SUM_W'(prod_rs_s2) + SUM_W'(prod_ic_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= head.valid;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			path_s1 <= head.req.path;
			last_s1 <= head.req.last;
			re_s1   <= head.req.re;
			im_s1   <= head.req.im;
			sin_s1  <= sin_val;
			cos_s1  <= cos_val;

			path_s2    <= path_s1;
			last_s2    <= last_s1;
			re_s2      <= re_s1;
			im_s2      <= im_s1;
			prod_rc_s2 <= PROD_W'(re_s1) * PROD_W'(cos_s1);
			prod_is_s2 <= PROD_W'(im_s1) * PROD_W'(sin_s1);
			prod_rs_s2 <= PROD_W'(re_s1) * PROD_W'(sin_s1);
			prod_ic_s2 <= PROD_W'(im_s1) * PROD_W'(cos_s1);

			out_i_q       <= (path_s2 == PATH_BEAM) ? re_s2 : round_sat(sum_re);
			out_q_q       <= (path_s2 == PATH_BEAM) ? im_s2 : round_sat(sum_im);
			vector_last_q <= last_s2;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_i       = out_i_q;
	assign out_q       = out_q_q;
	assign vector_last = vector_last_q;

	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !adv) |=> valid_s2)
		else $error("blocked stage lost its request");

	a_beam_passes: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && valid_s2 && path_s2 == PATH_BEAM)
			|=> (out_i_q == $past(re_s2) && out_q_q == $past(im_s2)))
		else $error("beamforming sample altered");

endmodule

// File: tb/sv/nco_frequency_offset_mixer_unit_tb.sv
module nco_frequency_offset_mixer_unit_tb;

	import nfo_pkg::*;

	// block configuration under test
	localparam int VEC_LEN     = VECTOR_SIZE_DEFAULT;
	localparam int LUT_BITS    = SINE_TABLE_BITS_DEFAULT;
	localparam int LUT_SIZE    = 1 << LUT_BITS;
	localparam int QUARTER     = 1 << (LUT_BITS - 2);
	localparam int QDEPTH      = QUEUE_DEPTH_DEFAULT;
	// queue plus the three-stage back pipe plus some slack
	localparam int DRAIN_CYCLES = QDEPTH + 3 + 8;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int REPORT_CAP   = 200;
	localparam int LONG_HOLD    = 150;

	typedef enum {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_TOGGLE
	} stall_style_t;

	// one output sample as it should come out of the mixer
	typedef struct {
		sample_t i;
		sample_t q;
		logic    last;
	} mixed_sample_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [0:0]         cfg_wdata;
	logic               in_valid;
	logic               in_stall;
	logic               mode;
	sample_t            est_i;
	sample_t            est_q;
	sample_t            beam_i;
	sample_t            beam_q;
	logic signed [31:0] freq_delta;
	logic               out_valid;
	logic               out_stall;
	sample_t            out_i;
	sample_t            out_q;
	logic               vector_last;

	nco_frequency_offset_mixer_unit #(
		.VECTOR_SIZE(VEC_LEN),
		.SINE_TABLE_BITS(LUT_BITS),
		.QUEUE_DEPTH(QDEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.est_i(est_i),
		.est_q(est_q),
		.beam_i(beam_i),
		.beam_q(beam_q),
		.freq_delta(freq_delta),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_i(out_i),
		.out_q(out_q),
		.vector_last(vector_last)
	);

	// mirror of the block state: nco phase, frequency offset, vector position, path
	logic [31:0]   nco_phase;
	logic [31:0]   nco_freq;
	int unsigned   vec_pos;
	logic          path_sel;
	int            sin_lut [LUT_SIZE];

	// samples still owed by the block, oldest first
	mixed_sample_t expected_samples[$];

	int            mismatches;
	int            reports;
	int unsigned   cycle_count;

	// sender burst shaping
	bit            gaps_on;
	int            burst_left;

	// long receiver hold, asked for by a test and timed by the receiver
	bit            long_hold_req;

	// clock, period 4
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// run guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("nco_frequency_offset_mixer_unit regression: fail");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// sine table, q1.15, 2^LUT_BITS points per turn
	// ---------------------------------------------------------------------

	// first-quadrant sine of k / QUARTER quarter turns; q30 angle, series to x^11
	function automatic int quarter_wave(longint unsigned k);
		longint unsigned ang;
		longint unsigned ang_sq;
		longint unsigned poly;
		longint unsigned prod;
		longint unsigned q15;
		ang    = (k * Q30_HALF_PI) >> (LUT_BITS - 2);
		ang_sq = (ang * ang) >> 30;
		// horner form, innermost term first
		poly   = Q30_ONE - ang_sq / 110;
		poly   = Q30_ONE - ((ang_sq * poly) >> 30) / 72;
		poly   = Q30_ONE - ((ang_sq * poly) >> 30) / 42;
		poly   = Q30_ONE - ((ang_sq * poly) >> 30) / 20;
		poly   = Q30_ONE - ((ang_sq * poly) >> 30) / 6;
		prod   = (ang * poly) >> 30;
		q15    = (prod + 16384) >> 15;
		if (q15 > 32767) begin
			q15 = 32767;
		end
		return int'(q15);
	endfunction

	function automatic void build_sine_lut();
		int quad;
		int pos;
		int v;
		for (int n = 0; n < LUT_SIZE; n++) begin
			quad = n / QUARTER;
			pos  = n % QUARTER;
			// odd quadrants run the quarter wave backwards, the upper half negates
			v = (quad % 2 == 1) ? quarter_wave(QUARTER - pos) : quarter_wave(pos);
			sin_lut[n] = (quad >= 2) ? -v : v;
		end
	endfunction

	// round half up from q2.30 to q1.15, then clamp to 16 bits
	function automatic sample_t round_to_q15(longint v);
		longint r;
		r = (v + 16384) >>> 15;
		if (r > 32767) begin
			r = 32767;
		end
		if (r < -32768) begin
			r = -32768;
		end
		return sample_t'(r);
	endfunction

	// ---------------------------------------------------------------------
	// mixer prediction, run once per accepted request
	// ---------------------------------------------------------------------

	function automatic void mix_request(logic md, sample_t ei, sample_t eq, sample_t bi,
			sample_t bq, logic [31:0] fd);
		mixed_sample_t        r;
		logic [LUT_BITS-1:0]  sin_idx;
		logic [LUT_BITS-1:0]  cos_idx;
		longint               s;
		longint               c;
		longint               a;
		longint               b;
		logic                 vec_end;
		// an update only moves the offset, no sample comes out
		if (md == MODE_UPDATE) begin
			nco_freq = nco_freq + fd;
			return;
		end
		vec_end = (vec_pos + 1 >= VEC_LEN);
		if (path_sel == PATH_BEAM) begin
			// straight through, phase frozen
			r.i = bi;
			r.q = bq;
		end else begin
			// phase steps down by the offset before the lookup
			nco_phase = nco_phase - nco_freq;
			sin_idx   = nco_phase[31 -: LUT_BITS];
			cos_idx   = sin_idx + LUT_BITS'(QUARTER);
			s = sin_lut[sin_idx];
			c = sin_lut[cos_idx];
			a = ei;
			b = eq;
			r.i = round_to_q15(a * c - b * s);
			r.q = round_to_q15(a * s + b * c);
		end
		r.last  = vec_end;
		vec_pos = vec_end ? 0 : vec_pos + 1;
		expected_samples.push_back(r);
	endfunction

	// ---------------------------------------------------------------------
	// result checking at the rising edge
	// ---------------------------------------------------------------------

	task automatic report_field(string field, int want, int got);
		mismatches++;
		// keep the log readable if everything goes wrong at once
		if (reports < REPORT_CAP) begin
			reports++;
			$display("%0t: %s expected %0d got %0d", $time, field, want, got);
		end
	endtask

	always @(posedge clk) begin
		mixed_sample_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_samples.size() == 0) begin
				mismatches++;
				$display("%0t: output %0d/%0d/%0d with no request pending", $time,
					out_i, out_q, vector_last);
			end else begin
				want = expected_samples.pop_front();
				if (out_i !== want.i) begin
					report_field("out_i", want.i, out_i);
				end
				if (out_q !== want.q) begin
					report_field("out_q", want.q, out_q);
				end
				if (vector_last !== want.last) begin
					report_field("vector_last", want.last, vector_last);
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// receiver: own stall pattern, plus a long hold on request
	// ---------------------------------------------------------------------

	initial begin
		stall_style_t style;
		int           style_left;
		int           hold_left;
		style      = STALL_NONE;
		style_left = 0;
		hold_left  = 0;
		out_stall  = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left     = LONG_HOLD;
			end
			if (hold_left > 0) begin
				// block fills up and pushes back on the input
				out_stall = 1'b1;
				hold_left--;
			end else begin
				if (style_left == 0) begin
					style      = stall_style_t'($urandom_range(0, 3));
					style_left = $urandom_range(20, 300);
				end
				style_left--;
				case (style)
					STALL_NONE:   out_stall = 1'b0;
					STALL_LIGHT:  out_stall = ($urandom_range(0, 7) == 0);
					STALL_HEAVY:  out_stall = ($urandom_range(0, 3) != 0);
					STALL_TOGGLE: out_stall = ~out_stall;
					default:      out_stall = 1'b0;
				endcase
			end
		end
	end

	// ---------------------------------------------------------------------
	// sender side
	// ---------------------------------------------------------------------

	// offers one request at the falling edge and holds it until accepted
	task automatic send_request(logic md, sample_t ei, sample_t eq, sample_t bi,
			sample_t bq, logic [31:0] fd);
		if (gaps_on) begin
			if (burst_left == 0) begin
				in_valid = 1'b0;
				repeat ($urandom_range(1, 8)) @(negedge clk);
				burst_left = $urandom_range(1, 24);
			end
			burst_left--;
		end
		mode       = md;
		est_i      = ei;
		est_q      = eq;
		beam_i     = bi;
		beam_q     = bq;
		freq_delta = fd;
		in_valid   = 1'b1;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		mix_request(md, ei, eq, bi, bq, fd);
		@(negedge clk);
	endtask

	// stop offering, wait for every owed sample, then let the pipe settle
	task automatic wait_idle();
		in_valid = 1'b0;
		while (expected_samples.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// path_select write, only called with the block idle
	task automatic write_path(logic sel);
		cfg_we    = 1'b1;
		cfg_wdata = sel;
		@(negedge clk);
		cfg_we    = 1'b0;
		path_sel  = sel;
	endtask

	function automatic sample_t pick_sample();
		case ($urandom_range(0, 9))
			0:       return 16'sh8000;
			1:       return 16'sh7fff;
			2:       return 16'sh0000;
			3:       return -16'sd1;
			default: return sample_t'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] pick_freq_delta();
		case ($urandom_range(0, 9))
			0:       return 32'h8000_0000;
			1:       return 32'h7fff_ffff;
			// slow drift, a few table steps per many samples
			2, 3:    return 32'($urandom_range(0, 2 ** 21)) - 32'h0010_0000;
			// whole table steps
			4, 5:    return {10'($urandom_range(0, LUT_SIZE - 1)), 22'd0};
			default: return $urandom;
		endcase
	endfunction

	task automatic send_random_request(int update_pct);
		logic md;
		md = ($urandom_range(0, 99) < update_pct) ? MODE_UPDATE : MODE_SAMPLE;
		send_request(md, pick_sample(), pick_sample(), pick_sample(), pick_sample(),
			pick_freq_delta());
	endtask

	// ---------------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------------

	// rotation path out of reset: zero phase, octant steps, rounding, saturation
	task automatic test_rotation_extremes();
		gaps_on = 1'b1;
		// zero offset: cosine at full scale, no rotation
		send_request(MODE_SAMPLE, 16'sh7fff, 16'sh8000, 16'sh1234, 16'sh4321, 32'h0);
		send_request(MODE_SAMPLE, 16'sh8000, 16'sh7fff, 16'sh0, 16'sh0, 32'hffff_ffff);
		send_request(MODE_SAMPLE, -16'sd1, -16'sd1, 16'sh0, 16'sh0, 32'h0);
		send_request(MODE_SAMPLE, 16'sh0, 16'sh0, 16'sh7fff, 16'sh8000, 32'h0);
		// offset of minus one eighth turn so the phase walks up by octants
		send_request(MODE_UPDATE, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 32'he000_0000);
		// equal parts at forty-five degrees push the sum past full scale
		send_request(MODE_SAMPLE, 16'sh7fff, 16'sh7fff, 16'sh0, 16'sh0, 32'h0);
		send_request(MODE_SAMPLE, 16'sh8000, 16'sh8000, 16'sh0, 16'sh0, 32'h0);
		send_request(MODE_SAMPLE, 16'sh7fff, 16'sh8000, 16'sh0, 16'sh0, 32'h0);
		send_request(MODE_SAMPLE, 16'sh8000, 16'sh7fff, 16'sh0, 16'sh0, 32'h0);
		send_request(MODE_SAMPLE, 16'sh8000, 16'sh8000, 16'sh0, 16'sh0, 32'h0);
		send_request(MODE_SAMPLE, 16'sh7fff, 16'sh7fff, 16'sh0, 16'sh0, 32'h0);
		send_request(MODE_SAMPLE, 16'sh4000, -16'sd1, 16'sh0, 16'sh0, 32'h0);
		// offset wraps through the signed extremes
		send_request(MODE_UPDATE, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 32'h7fff_ffff);
		send_request(MODE_SAMPLE, 16'sh7fff, 16'sh0, 16'sh0, 16'sh0, 32'h0);
		send_request(MODE_UPDATE, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 32'h8000_0000);
		send_request(MODE_SAMPLE, 16'sh0, 16'sh7fff, 16'sh0, 16'sh0, 32'h0);
		send_request(MODE_UPDATE, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 32'hffff_ffff);
		send_request(MODE_SAMPLE, 16'sh5555, 16'shaaaa, 16'sh0, 16'sh0, 32'h0);
		wait_idle();
	endtask

	// pass-through path: beam fields out unchanged, updates still land
	task automatic test_beam_passthrough();
		write_path(PATH_BEAM);
		send_request(MODE_SAMPLE, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff, 32'h0);
		send_request(MODE_SAMPLE, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 32'h0);
		send_request(MODE_UPDATE, 16'sh1, 16'sh1, 16'sh1, 16'sh1, 32'h1234_5678);
		send_request(MODE_SAMPLE, 16'sh1, 16'sh2, -16'sd1, 16'sh0, 32'hffff_ffff);
		wait_idle();
		// back to rotation: the offset added above must now show
		write_path(PATH_EST);
		send_request(MODE_SAMPLE, 16'sh7fff, 16'sh0, 16'sh0, 16'sh0, 32'h0);
		wait_idle();
	endtask

	// receiver holds off for a long stretch while requests keep coming
	task automatic test_backpressure();
		gaps_on       = 1'b0;
		long_hold_req = 1'b1;
		for (int n = 0; n < 40; n++) begin
			send_random_request(10);
		end
		wait_idle();
		gaps_on = 1'b1;
	endtask

	// random traffic over several path settings, with and without gaps
	task automatic test_random_traffic();
		for (int ph = 0; ph < 6; ph++) begin
			wait_idle();
			case (ph)
				0, 2:    write_path(PATH_EST);
				1, 3:    write_path(PATH_BEAM);
				default: write_path(logic'($urandom_range(0, 1)));
			endcase
			// one phase runs back to back
			gaps_on    = (ph != 2);
			burst_left = 0;
			for (int n = 0; n < 200; n++) begin
				send_random_request(ph == 4 ? 40 : 15);
			end
		end
		wait_idle();
	endtask

	// ---------------------------------------------------------------------
	// main sequence
	// ---------------------------------------------------------------------

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = 1'b0;
		in_valid      = 1'b0;
		mode          = MODE_SAMPLE;
		est_i         = '0;
		est_q         = '0;
		beam_i        = '0;
		beam_q        = '0;
		freq_delta    = '0;
		nco_phase     = '0;
		nco_freq      = '0;
		vec_pos       = 0;
		path_sel      = PATH_EST;
		mismatches    = 0;
		reports       = 0;
		cycle_count   = 0;
		gaps_on       = 1'b1;
		burst_left    = 0;
		long_hold_req = 1'b0;
		build_sine_lut();

		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_rotation_extremes();
		test_beam_passthrough();
		test_backpressure();
		test_random_traffic();

		if (mismatches == 0) begin
			$display("nco_frequency_offset_mixer_unit regression: pass");
		end else begin
			$display("nco_frequency_offset_mixer_unit regression: fail");
		end
		$finish;
	end

endmodule
